// ===== rtl/ptpd_pkg.sv =====
// Package for the path traversal pattern detector.
// Holds the byte width, the traversal pattern table and the pattern lengths.
// No dependencies.
package ptpd_pkg;

	localparam int BYTE_W      = 8;
	localparam int PAT_COUNT   = 10;
	localparam int PAT_MAX_LEN = 15;
	localparam int LEN_W       = $clog2(PAT_MAX_LEN + 1);

	typedef logic [BYTE_W*PAT_MAX_LEN-1:0] pat_text_t;
	typedef logic [LEN_W-1:0]              pat_len_t;

	// Each entry is right aligned: bits [7:0] hold the final character,
	// byte k holds the character k positions before it.
	localparam pat_text_t PAT_TEXT [PAT_COUNT] = '{
		pat_text_t'("../"),
		pat_text_t'("%2e%2e%2f"),
		pat_text_t'("%2e%2e/"),
		pat_text_t'("..%2f"),
		pat_text_t'("%2e%2e%5c"),
		pat_text_t'("%2e%2e\\"),
		pat_text_t'("..%5c"),
		pat_text_t'("%252e%252e%255c"),
		pat_text_t'("..%255c"),
		pat_text_t'("..\\")
	};

	localparam pat_len_t PAT_LEN [PAT_COUNT] = '{
		pat_len_t'(3), pat_len_t'(9), pat_len_t'(7), pat_len_t'(5), pat_len_t'(9),
		pat_len_t'(7), pat_len_t'(5), pat_len_t'(15), pat_len_t'(7), pat_len_t'(3)
	};

endpackage

// ===== rtl/path_traversal_pattern_detector.sv =====
// Top level of the path traversal pattern detector.
// Depends on ptpd_pkg for the pattern table and byte width.
//
// Usage:
//   Slave stream: one path character per item on s_axis_tdata, with
//   s_axis_tlast high on the final character of the path.
//   Master stream: one item per path, sent after its final character;
//   m_axis_tdata[0] is set when any traversal pattern occurred anywhere
//   in the path.
//   Each incoming character is registered, then compared against all ten
//   patterns using the registered history window; the result goes into
//   the output register. A final character's result is loaded there as
//   the character leaves the input register. Throughput is one character
//   per cycle while no result waits on a stalled receiver; the parallel
//   pattern compare in the match stage sets that figure.
//   Reset clears the history window, the sticky hit flag and all valid
//   flags. When the receiver stalls with a result waiting, the match
//   stage holds and the input register still takes one more character;
//   s_axis_tready drops only when both are full.
//   After a final character the window and the hit flag are cleared, so
//   no pattern spans two paths.
module path_traversal_pattern_detector #(
	parameter int LONGEST_PATTERN = 15
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// tdata fields from bit 0: path_byte[7:0]
	input  logic [ptpd_pkg::BYTE_W-1:0]   s_axis_tdata,
	// tlast: end_of_path
	input  logic                          s_axis_tlast,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// tdata fields from bit 0: traversal_found[0], zero fill [7:1]
	output logic [ptpd_pkg::BYTE_W-1:0]   m_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready
);
	import ptpd_pkg::*;

	localparam int WIN_DEPTH = LONGEST_PATTERN - 1;

	logic [BYTE_W-1:0] window_q [WIN_DEPTH];
	logic              hit_q;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	logic              valid_s1;
	logic              found_q;
	logic              out_valid_q;

	logic              advance;
	logic [BYTE_W-1:0] recent [LONGEST_PATTERN];
	logic [PAT_COUNT-1:0] pat_hit;
	logic              hit_next;

	// Match stage moves when the output register is free or being drained
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Build the history view: current byte first, then older bytes
	always_comb begin
		recent[0] = byte_s1;
		for (int k = 1; k < LONGEST_PATTERN; k++) begin
			recent[k] = window_q[k-1];
		end
	end

	// Compare against every pattern in parallel
	always_comb begin
		for (int p = 0; p < PAT_COUNT; p++) begin
			pat_hit[p] = 1'b1;
			for (int k = 0; k < PAT_MAX_LEN; k++) begin
				if (k < int'(PAT_LEN[p]) && recent[k] != PAT_TEXT[p][BYTE_W*k +: BYTE_W]) begin
					pat_hit[p] = 1'b0;
				end
			end
		end
	end

	assign hit_next = hit_q | (|pat_hit);

	// Advance the window and sticky flag; clear both at end of path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN_DEPTH; k++) begin
				window_q[k] <= '0;
			end
			hit_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			if (last_s1) begin
				for (int k = 0; k < WIN_DEPTH; k++) begin
					window_q[k] <= '0;
				end
				hit_q <= 1'b0;
			end else begin
				window_q[0] <= byte_s1;
				for (int k = 1; k < WIN_DEPTH; k++) begin
					window_q[k] <= window_q[k-1];
				end
				hit_q <= hit_next;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && last_s1) begin
			found_q <= hit_next;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(BYTE_W-1){1'b0}}, found_q};

`ifndef SYNTHESIS
	// Input side stalls only when both stages are full and the output is blocked
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && out_valid_q && !m_axis_tready))
		else $error("input stalled without a blocked output");

	// A final character always produces a result next cycle
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && last_s1) |=> m_axis_tvalid)
		else $error("final character produced no result");

	// The sticky flag is clear once a path ends
	a_hit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && last_s1) |=> !hit_q)
		else $error("hit flag survived end of path");

	// Non-final characters never create a result
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !(valid_s1 && last_s1)) |=> !m_axis_tvalid)
		else $error("result without a final character");
`endif

endmodule
